// ===== rtl/lsie_pkg.sv =====
`timescale 1ns / 1ps
package lsie_pkg;

   // fixed field widths of the channel words
   localparam int unsigned CMD_W    = 3;
   localparam int unsigned FIELD_W  = 32;
   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned LNO_W    = 16;
   localparam int unsigned FLINE_W  = 12;
   localparam int unsigned LTOTAL_W = 13;
   localparam int unsigned STATUS_W = 2;

   // command codes
   localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd0;
   localparam logic [CMD_W-1:0] CMD_SCAN   = 3'd1;
   localparam logic [CMD_W-1:0] CMD_INSERT = 3'd2;
   localparam logic [CMD_W-1:0] CMD_ADDNL  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_DELETE = 3'd4;
   localparam logic [CMD_W-1:0] CMD_LOCATE = 3'd5;
   localparam logic [CMD_W-1:0] CMD_FIND   = 3'd6;
   localparam logic [CMD_W-1:0] CMD_NOP    = 3'd7;

   // status codes
   localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NOLINE = 2'd2;

   localparam logic [BYTE_W-1:0] NEWLINE_BYTE = 8'd10;

   // one result word
   typedef struct packed {
      logic [FIELD_W-1:0]  offset_out;
      logic [FIELD_W-1:0]  line_begin;
      logic [FIELD_W-1:0]  line_finish;
      logic [FLINE_W-1:0]  found_line;
      logic [FIELD_W-1:0]  found_column;
      logic [LTOTAL_W-1:0] line_total_out;
      logic [STATUS_W-1:0] status;
   } rsp_word_type;

endpackage

// ===== rtl/lsie_req_if.sv =====
`timescale 1ns / 1ps
interface lsie_req_if import lsie_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [CMD_W-1:0]   cmd;
   logic [FIELD_W-1:0] position;
   logic [FIELD_W-1:0] length;
   logic [FIELD_W-1:0] newline_rel;
   logic [BYTE_W-1:0]  byte_value;
   logic [LNO_W-1:0]   line_number;
   logic [LNO_W-1:0]   column;

   modport source (output valid, cmd, position, length, newline_rel, byte_value,
                   line_number, column, input ready);
   modport sink (input valid, cmd, position, length, newline_rel, byte_value,
                 line_number, column, output ready);
endinterface

// ===== rtl/lsie_rsp_if.sv =====
`timescale 1ns / 1ps
interface lsie_rsp_if import lsie_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [FIELD_W-1:0]  offset_out;
   logic [FIELD_W-1:0]  line_begin;
   logic [FIELD_W-1:0]  line_finish;
   logic [FLINE_W-1:0]  found_line;
   logic [FIELD_W-1:0]  found_column;
   logic [LTOTAL_W-1:0] line_total_out;
   logic [STATUS_W-1:0] status;

   modport source (output valid, offset_out, line_begin, line_finish, found_line,
                   found_column, line_total_out, status, input ready);
   modport sink (input valid, offset_out, line_begin, line_finish, found_line,
                 found_column, line_total_out, status, output ready);
endinterface

// ===== rtl/line_start_index_engine.sv =====
`timescale 1ns / 1ps
// Line-start index engine: keeps the sorted start offsets of the lines of a text buffer in
// one single-port-write, single-port-read memory of MAX_LINES entries, plus the line count
// and text length. One command word in gives one result word out. A scanned newline or
// added newline walks down from the table end, moving each larger entry up one; insert
// shift, delete and find walk the table one entry at a time (a memory read, then the
// compare). Entry 0 is always offset 0 and is never read from the memory, so no clearing
// pass is needed after reset. A new command is taken while the last result waits.
module line_start_index_engine
   import lsie_pkg::*;
#(
   parameter int unsigned MAX_LINES    = 4096,
   parameter int unsigned OFFSET_WIDTH = 32
) (
   input  logic       clock,
   input  logic       reset,
   lsie_req_if.sink   req_if,
   lsie_rsp_if.source rsp_if
);

   localparam int unsigned IW = $clog2(MAX_LINES);
   localparam int unsigned CW = $clog2(MAX_LINES + 1);
   localparam int unsigned OW = OFFSET_WIDTH;

   typedef enum logic [16:0] {
      S_IDLE   = 17'h00001,
      S_ADD_RD = 17'h00002,
      S_ADD_CK = 17'h00004,
      S_SH_RD  = 17'h00008,
      S_SH_CK  = 17'h00010,
      S_DF_RD  = 17'h00020,
      S_DF_CK  = 17'h00040,
      S_DL_RD  = 17'h00080,
      S_DL_CK  = 17'h00100,
      S_MV_RD  = 17'h00200,
      S_MV_WR  = 17'h00400,
      S_LOC_RD = 17'h00800,
      S_LOC_B  = 17'h01000,
      S_LOC_F  = 17'h02000,
      S_FD_RD  = 17'h04000,
      S_FD_CK  = 17'h08000,
      S_RESP   = 17'h10000
   } state_type;

   state_type    state_ff, state_in;
   logic [CW-1:0] total_ff, total_in;
   logic [OW-1:0] tlen_ff, tlen_in;
   logic [OW-1:0] pos_ff, pos_in;
   logic [OW-1:0] len_ff, len_in;
   logic [OW-1:0] val_ff, val_in;
   logic [OW-1:0] begin_ff, begin_in;
   logic [LNO_W-1:0] col_ff, col_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [CW-1:0] dst_ff, dst_in;
   rsp_word_type  res_ff, res_in;
   rsp_word_type  rsp_ff, rsp_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // line start memory
   logic [OW-1:0] mem [MAX_LINES];
   logic          mem_we;
   logic [IW-1:0] mem_waddr, mem_raddr;
   logic [OW-1:0] mem_wdata;
   logic [OW-1:0] rdata_ff;
   logic          rd_zero_ff;
   logic [OW-1:0] rd_val;

   logic [OW-1:0] pos_c, len_c, rel_c, tl1_c, rem_c, clip_c, fin_c;
   logic [OW:0]   sum_c;
   logic [CW-1:0] idx1_c;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff   <= mem[mem_raddr];
      rd_zero_ff <= (mem_raddr == '0);
   end

   // entry zero always reads as offset zero
   assign rd_val = rd_zero_ff ? '0 : rdata_ff;

   assign pos_c  = OW'(req_if.position);
   assign len_c  = OW'(req_if.length);
   assign rel_c  = OW'(req_if.newline_rel);
   assign tl1_c  = tlen_ff + OW'(1);
   assign rem_c  = tlen_ff - pos_c;
   assign clip_c = (pos_c >= tlen_ff) ? '0 : ((len_c > rem_c) ? rem_c : len_c);
   assign idx1_c = idx_ff + CW'(1);
   assign fin_c  = (idx_ff < total_ff) ? rd_val : tlen_ff;
   assign sum_c  = {1'b0, begin_ff} + (OW+1)'(col_ff);

   // command sequencer
   always_comb begin
      state_in     = state_ff;
      total_in     = total_ff;
      tlen_in      = tlen_ff;
      pos_in       = pos_ff;
      len_in       = len_ff;
      val_in       = val_ff;
      begin_in     = begin_ff;
      col_in       = col_ff;
      idx_in       = idx_ff;
      dst_in       = dst_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      mem_we       = 1'b0;
      mem_waddr    = idx_ff[IW-1:0];
      mem_wdata    = rd_val;
      mem_raddr    = idx_ff[IW-1:0];
      unique case (state_ff)
         S_IDLE: begin
            if (req_if.valid) begin
               res_in   = '0;
               pos_in   = pos_c;
               len_in   = len_c;
               col_in   = req_if.column;
               begin_in = '0;
               state_in = S_RESP;
               unique case (req_if.cmd) inside
                  CMD_CLEAR: begin
                     total_in = CW'(1);
                     tlen_in  = '0;
                  end
                  CMD_SCAN, CMD_ADDNL: begin
                     if (req_if.cmd == CMD_SCAN) begin
                        tlen_in = tl1_c;
                        val_in  = tl1_c;
                     end else begin
                        val_in  = pos_c + rel_c + OW'(1);
                     end
                     if (req_if.cmd == CMD_ADDNL || req_if.byte_value == NEWLINE_BYTE) begin
                        if (total_ff >= CW'(MAX_LINES)) begin
                           res_in.status = ST_FULL;
                        end else begin
                           idx_in   = total_ff;
                           state_in = S_ADD_RD;
                        end
                     end
                  end
                  CMD_INSERT: begin
                     if (len_c != '0) begin
                        tlen_in  = tlen_ff + len_c;
                        idx_in   = CW'(1);
                        state_in = S_SH_RD;
                     end
                  end
                  CMD_DELETE: begin
                     if (clip_c != '0) begin
                        len_in   = clip_c;
                        val_in   = pos_c + clip_c;
                        tlen_in  = tlen_ff - clip_c;
                        idx_in   = CW'(1);
                        state_in = S_DF_RD;
                     end
                  end
                  CMD_LOCATE: begin
                     if ({1'b0, req_if.line_number} >= (LNO_W+1)'(total_ff)) begin
                        res_in.offset_out  = FIELD_W'(tlen_ff);
                        res_in.line_begin  = FIELD_W'(tlen_ff);
                        res_in.line_finish = FIELD_W'(tlen_ff);
                        res_in.status      = ST_NOLINE;
                     end else begin
                        idx_in   = CW'(req_if.line_number);
                        state_in = S_LOC_RD;
                     end
                  end
                  CMD_FIND: begin
                     idx_in   = '0;
                     state_in = S_FD_RD;
                  end
                  default: ;
               endcase
            end
         end
         // sorted insert: move larger entries up one, from the top down
         S_ADD_RD: begin
            mem_raddr = IW'(idx_ff - CW'(1));
            state_in  = S_ADD_CK;
         end
         S_ADD_CK: begin
            mem_we = 1'b1;
            if (rd_val > val_ff) begin
               idx_in   = idx_ff - CW'(1);
               state_in = S_ADD_RD;
            end else begin
               mem_wdata = val_ff;
               total_in  = total_ff + CW'(1);
               state_in  = S_RESP;
            end
         end
         // insert shift over the whole table
         S_SH_RD: begin
            state_in = (idx_ff >= total_ff) ? S_RESP : S_SH_CK;
         end
         S_SH_CK: begin
            mem_we    = (rd_val > pos_ff);
            mem_wdata = rd_val + len_ff;
            idx_in    = idx1_c;
            state_in  = S_SH_RD;
         end
         // delete: find first start past position
         S_DF_RD: begin
            if (idx_ff >= total_ff) begin
               dst_in   = idx_ff;
               state_in = S_DL_RD;
            end else begin
               state_in = S_DF_CK;
            end
         end
         S_DF_CK: begin
            if (rd_val <= pos_ff) begin
               idx_in   = idx1_c;
               state_in = S_DF_RD;
            end else begin
               dst_in   = idx_ff;
               state_in = S_DL_RD;
            end
         end
         // delete: find first start past the range end
         S_DL_RD: begin
            state_in = (idx_ff >= total_ff) ? S_MV_RD : S_DL_CK;
         end
         S_DL_CK: begin
            if (rd_val <= val_ff) begin
               idx_in   = idx1_c;
               state_in = S_DL_RD;
            end else begin
               state_in = S_MV_RD;
            end
         end
         // delete: close the gap and pull later starts down
         S_MV_RD: begin
            if (idx_ff >= total_ff) begin
               total_in = total_ff - idx_ff + dst_ff;
               state_in = S_RESP;
            end else begin
               state_in = S_MV_WR;
            end
         end
         S_MV_WR: begin
            mem_we    = 1'b1;
            mem_waddr = dst_ff[IW-1:0];
            mem_wdata = rd_val - len_ff;
            idx_in    = idx1_c;
            dst_in    = dst_ff + CW'(1);
            state_in  = S_MV_RD;
         end
         // locate: line start, then next start
         S_LOC_RD: begin
            idx_in   = idx1_c;
            state_in = S_LOC_B;
         end
         S_LOC_B: begin
            begin_in = rd_val;
            state_in = S_LOC_F;
         end
         S_LOC_F: begin
            res_in.line_begin  = FIELD_W'(begin_ff);
            res_in.line_finish = FIELD_W'(fin_c);
            if (sum_c > (OW+1)'(fin_c)) begin
               res_in.offset_out = FIELD_W'(fin_c > tlen_ff ? tlen_ff : fin_c);
            end else if (sum_c > (OW+1)'(tlen_ff)) begin
               res_in.offset_out = FIELD_W'(tlen_ff);
            end else begin
               res_in.offset_out = FIELD_W'(sum_c[OW-1:0]);
            end
            state_in = S_RESP;
         end
         // find: walk while the next start is not past position
         S_FD_RD: begin
            mem_raddr = idx1_c[IW-1:0];
            if (idx1_c >= total_ff) begin
               res_in.found_line   = FLINE_W'(idx_ff);
               res_in.line_begin   = FIELD_W'(begin_ff);
               res_in.line_finish  = FIELD_W'(tlen_ff);
               res_in.found_column = FIELD_W'(pos_ff - begin_ff);
               state_in            = S_RESP;
            end else begin
               state_in = S_FD_CK;
            end
         end
         S_FD_CK: begin
            if (rd_val <= pos_ff) begin
               idx_in   = idx1_c;
               begin_in = rd_val;
               state_in = S_FD_RD;
            end else begin
               res_in.found_line   = FLINE_W'(idx_ff);
               res_in.line_begin   = FIELD_W'(begin_ff);
               res_in.line_finish  = FIELD_W'(rd_val);
               res_in.found_column = FIELD_W'(pos_ff - begin_ff);
               state_in            = S_RESP;
            end
         end
         // hand the word to the output register
         S_RESP: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_in                = res_ff;
               rsp_in.line_total_out = LTOTAL_W'(total_ff);
               rsp_valid_in          = 1'b1;
               state_in              = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         total_ff     <= CW'(1);
         tlen_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         tlen_ff      <= tlen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff   <= pos_in;
      len_ff   <= len_in;
      val_ff   <= val_in;
      begin_ff <= begin_in;
      col_ff   <= col_in;
      idx_ff   <= idx_in;
      dst_ff   <= dst_in;
      res_ff   <= res_in;
      rsp_ff   <= rsp_in;
   end

   assign req_if.ready          = (state_ff == S_IDLE);
   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.offset_out     = rsp_ff.offset_out;
   assign rsp_if.line_begin     = rsp_ff.line_begin;
   assign rsp_if.line_finish    = rsp_ff.line_finish;
   assign rsp_if.found_line     = rsp_ff.found_line;
   assign rsp_if.found_column   = rsp_ff.found_column;
   assign rsp_if.line_total_out = rsp_ff.line_total_out;
   assign rsp_if.status         = rsp_ff.status;

   // line count stays within the table
   a_total_range: assert property (@(posedge clock) disable iff (reset)
      (total_ff != '0) && (total_ff <= CW'(MAX_LINES)))
      else $error("line count out of range");

   // entry zero is never overwritten
   a_no_entry0_write: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (mem_waddr != '0))
      else $error("write to entry zero");

   // an accepted word always starts work
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready) |=> (state_ff != S_IDLE))
      else $error("accepted word dropped");

endmodule
